@@ design/lps_pkg.sv @@
// Shared types and constants for the latency percentile statistics unit.
`timescale 1ns / 1ps
`default_nettype none
package lps_pkg;
   localparam int MAX_SAMPLES = 16384;
   localparam int ADDR_BITS = $clog2(MAX_SAMPLES);
   localparam int CNT_BITS = ADDR_BITS + 1;
   localparam int SUM_BITS = 46;
   localparam int NUM_CSR = 2;

   localparam logic [31:0] LOW_THRESHOLD_RESET = 32'd10000;
   localparam logic [31:0] HIGH_THRESHOLD_RESET = 32'd100000;
   localparam logic [0:0] CSR_LOW_THRESHOLD = 1'b0;
   localparam logic [0:0] CSR_HIGH_THRESHOLD = 1'b1;

   typedef struct packed {
      logic [31:0] latency_ns;
      logic        last_sample;
   } req_type;

   typedef struct packed {
      logic [31:0] min_latency;
      logic [31:0] max_latency;
      logic [31:0] mean_latency;
      logic [31:0] median_latency;
      logic [31:0] p99_latency;
      logic [31:0] p999_latency;
      logic [14:0] count_above_low;
      logic [14:0] count_above_high;
      logic [14:0] sample_count;
      logic        samples_dropped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_INIT,
      ST_SORT_PASS,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SORT_SWAP,
      ST_PICK,
      ST_PICK_WAIT,
      ST_DIV,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

@@ design/lps_divider.sv @@
// Restoring divider that produces the mean, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lps_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lps_pkg::SUM_BITS-1:0]  dividend,
   input  wire logic [lps_pkg::CNT_BITS-1:0]  divisor,
   output logic                               done,
   output logic [lps_pkg::SUM_BITS-1:0]       quotient
);
   localparam int STEP_BITS = $clog2(lps_pkg::SUM_BITS + 1);

   logic [lps_pkg::SUM_BITS-1:0] quo_ff, quo_in;
   logic [lps_pkg::CNT_BITS:0]   rem_ff, rem_in;
   logic [lps_pkg::CNT_BITS-1:0] div_ff, div_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic                         busy_ff, busy_in;
   logic [lps_pkg::CNT_BITS:0]   trial;

   // One shift-and-subtract step per cycle.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      trial = {rem_ff[lps_pkg::CNT_BITS-1:0], quo_ff[lps_pkg::SUM_BITS-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         step_in = STEP_BITS'(lps_pkg::SUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[lps_pkg::SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[lps_pkg::SUM_BITS-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = busy_ff && (step_ff == STEP_BITS'(1));
   assign quotient = quo_in;
endmodule
`default_nettype wire

@@ design/latency_percentile_stats_unit.sv @@
// Top level of the latency percentile statistics unit.
`timescale 1ns / 1ps
`default_nettype none
// Samples load one word per cycle, while the unit is ready, into a 16384-entry
// store while a running sum and two threshold counts are kept. The word marked
// last triggers an odd-even transposition sort of the n kept samples through
// one shared compare-and-swap unit working on the store: n passes of about n/2
// pairs each; a pair reads its lower and upper words and compares them, and an
// exchanged pair then has both words rewritten. Then come store reads for the
// percentiles, a start of the divider and the divide for the mean, and the
// posting of the result. The unit is not ready during that work; the result
// word then waits in an output register until taken, while the next set may
// already load. There is no clearing pass after reset.
module latency_percentile_stats_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire lps_pkg::req_type    req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output lps_pkg::rsp_type         rsp_data,
   input  wire logic                csr_write,
   input  wire logic [0:0]          csr_index,
   input  wire logic [31:0]         csr_wdata
);
   localparam int AB = lps_pkg::ADDR_BITS;
   localparam int CB = lps_pkg::CNT_BITS;
   // Reciprocals ceil(2^20 / 100) and ceil(2^24 / 1000), exact for n below 16384.
   localparam logic [13:0] RECIP_100 = 14'd10486;
   localparam logic [14:0] RECIP_1000 = 15'd16778;

   lps_pkg::state_type state_ff, state_in;

   logic [31:0] store [lps_pkg::MAX_SAMPLES];
   logic [31:0] rd_data_ff;
   logic [AB-1:0] rd_addr;
   logic          wr_en;
   logic [AB-1:0] wr_addr;
   logic [31:0]   wr_data;

   logic [31:0] low_thr_ff, high_thr_ff;
   logic [CB-1:0] count_ff, count_in;
   logic [lps_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [CB-1:0] low_cnt_ff, low_cnt_in, high_cnt_ff, high_cnt_in;
   logic          drop_ff, drop_in;

   // Sort sequencing: pass number, pair index, lower word of the pair.
   logic [CB-1:0] pass_ff, pass_in;
   logic [CB-1:0] idx_ff, idx_in;
   logic [31:0]   a_ff, a_in;
   logic [2:0]    pick_ff, pick_in;

   lps_pkg::rsp_type work_ff, work_in;
   lps_pkg::rsp_type out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic div_start, div_done;
   logic [lps_pkg::SUM_BITS-1:0] div_q;

   // Percentile indices: n*50/100 is n/2, n*99/100 is n-1-(n-1)/100 and
   // n*999/1000 is n-1-(n-1)/1000, the divisions done by reciprocal products.
   logic [CB-1:0]  n_less1;
   logic [CB+13:0] q100_prod;
   logic [CB+14:0] q1000_prod;
   logic [AB-1:0]  idx_p50, idx_p99, idx_p999, idx_max;
   assign n_less1 = count_ff - 1'b1;
   assign q100_prod = (CB+14)'(n_less1) * (CB+14)'(RECIP_100);
   assign q1000_prod = (CB+15)'(n_less1) * (CB+15)'(RECIP_1000);
   assign idx_p50 = AB'(count_ff >> 1);
   assign idx_p99 = AB'(n_less1 - CB'(q100_prod[CB+13:20]));
   assign idx_p999 = AB'(n_less1 - CB'(q1000_prod[CB+14:24]));
   assign idx_max = AB'(n_less1);

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == lps_pkg::ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = out_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff <= lps_pkg::LOW_THRESHOLD_RESET;
         high_thr_ff <= lps_pkg::HIGH_THRESHOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            lps_pkg::CSR_LOW_THRESHOLD:  low_thr_ff <= csr_wdata;
            lps_pkg::CSR_HIGH_THRESHOLD: high_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pair addresses of the current pass: even passes start at 0, odd at 1.
   logic [AB-1:0] pair_lo, pair_hi;
   logic [CB-1:0] pair_hi_wide;
   assign pair_hi_wide = idx_ff + 1'b1;
   assign pair_lo = idx_ff[AB-1:0];
   assign pair_hi = pair_hi_wide[AB-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lps_pkg::ST_LOAD:
            if (accept && req_data.last_sample) state_in = lps_pkg::ST_SORT_INIT;
         lps_pkg::ST_SORT_INIT: state_in = lps_pkg::ST_SORT_PASS;
         lps_pkg::ST_SORT_PASS:
            if (pass_ff == count_ff) state_in = lps_pkg::ST_PICK;
            else if (pair_hi_wide >= count_ff) state_in = lps_pkg::ST_SORT_PASS;
            else state_in = lps_pkg::ST_SORT_RD;
         lps_pkg::ST_SORT_RD: state_in = lps_pkg::ST_SORT_CMP;
         lps_pkg::ST_SORT_CMP:
            if (a_ff > rd_data_ff) state_in = lps_pkg::ST_SORT_SWAP;
            else state_in = lps_pkg::ST_SORT_PASS;
         lps_pkg::ST_SORT_SWAP: state_in = lps_pkg::ST_SORT_PASS;
         lps_pkg::ST_PICK:
            if (pick_ff == 3'd5) state_in = lps_pkg::ST_PICK_WAIT;
         lps_pkg::ST_PICK_WAIT: state_in = lps_pkg::ST_DIV;
         lps_pkg::ST_DIV: if (div_done) state_in = lps_pkg::ST_DONE;
         lps_pkg::ST_DONE: if (!rsp_valid_ff) state_in = lps_pkg::ST_LOAD;
         default: state_in = lps_pkg::ST_LOAD;
      endcase
   end

   // Datapath and store port control.
   always_comb begin
      count_in = count_ff;
      sum_in = sum_ff;
      low_cnt_in = low_cnt_ff;
      high_cnt_in = high_cnt_ff;
      drop_in = drop_ff;
      pass_in = pass_ff;
      idx_in = idx_ff;
      a_in = a_ff;
      pick_in = pick_ff;
      work_in = work_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en = 1'b0;
      wr_addr = AB'(count_ff);
      wr_data = req_data.latency_ns;
      rd_addr = pair_lo;
      div_start = 1'b0;
      unique case (state_ff)
         lps_pkg::ST_LOAD: begin
            if (accept) begin
               if (count_ff < CB'(lps_pkg::MAX_SAMPLES)) begin
                  wr_en = 1'b1;
                  count_in = count_ff + 1'b1;
                  sum_in = sum_ff + lps_pkg::SUM_BITS'(req_data.latency_ns);
                  if (req_data.latency_ns > low_thr_ff) low_cnt_in = low_cnt_ff + 1'b1;
                  if (req_data.latency_ns > high_thr_ff) high_cnt_in = high_cnt_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end
         end
         lps_pkg::ST_SORT_INIT: begin
            pass_in = '0;
            idx_in = '0;
         end
         lps_pkg::ST_SORT_PASS: begin
            // Read the lower word of the pair, or move on to the next pass.
            rd_addr = pair_lo;
            if (pass_ff != count_ff && pair_hi_wide >= count_ff) begin
               pass_in = pass_ff + 1'b1;
               idx_in = {{(CB-1){1'b0}}, ~pass_ff[0]};
            end
            pick_in = '0;
         end
         lps_pkg::ST_SORT_RD: begin
            a_in = rd_data_ff;
            rd_addr = pair_hi;
         end
         lps_pkg::ST_SORT_CMP: begin
            // Shared compare; an out-of-order pair gets its lower word now.
            if (a_ff > rd_data_ff) begin
               wr_en = 1'b1;
               wr_addr = pair_lo;
               wr_data = rd_data_ff;
            end else begin
               idx_in = idx_ff + CB'(2);
            end
         end
         lps_pkg::ST_SORT_SWAP: begin
            // The upper word of an exchanged pair takes the old lower word.
            wr_en = 1'b1;
            wr_addr = pair_hi;
            wr_data = a_ff;
            idx_in = idx_ff + CB'(2);
         end
         lps_pkg::ST_PICK: begin
            unique case (pick_ff)
               3'd0: rd_addr = '0;
               3'd1: rd_addr = idx_max;
               3'd2: rd_addr = idx_p50;
               3'd3: rd_addr = idx_p99;
               default: rd_addr = idx_p999;
            endcase
            pick_in = pick_ff + 1'b1;
            case (pick_ff)
               3'd1: work_in.min_latency = rd_data_ff;
               3'd2: work_in.max_latency = rd_data_ff;
               3'd3: work_in.median_latency = rd_data_ff;
               3'd4: work_in.p99_latency = rd_data_ff;
               3'd5: work_in.p999_latency = rd_data_ff;
               default: ;
            endcase
         end
         lps_pkg::ST_PICK_WAIT: div_start = 1'b1;
         lps_pkg::ST_DIV: begin
            if (div_done) begin
               work_in.mean_latency = div_q[31:0];
               work_in.count_above_low = low_cnt_ff;
               work_in.count_above_high = high_cnt_ff;
               work_in.sample_count = count_ff;
               work_in.samples_dropped = drop_ff;
            end
         end
         lps_pkg::ST_DONE: begin
            // Post the result once the output register is free.
            if (!rsp_valid_ff) begin
               out_in = work_ff;
               rsp_valid_in = 1'b1;
               count_in = '0;
               sum_in = '0;
               low_cnt_in = '0;
               high_cnt_in = '0;
               drop_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   lps_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sample store with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) store[wr_addr] <= wr_data;
      rd_data_ff <= store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lps_pkg::ST_LOAD;
         count_ff <= '0;
         sum_ff <= '0;
         low_cnt_ff <= '0;
         high_cnt_ff <= '0;
         drop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         low_cnt_ff <= low_cnt_in;
         high_cnt_ff <= high_cnt_in;
         drop_ff <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_ff <= pass_in;
      idx_ff <= idx_in;
      a_ff <= a_in;
      pick_ff <= pick_in;
      work_ff <= work_in;
      out_ff <= out_in;
   end

`ifndef SYNTHESIS
   // A waiting result word holds its payload until it is taken.
   rsp_hold_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)));
   // The store never holds more than its size.
   count_range_check: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(lps_pkg::MAX_SAMPLES));
   // Every compared pair lies inside the kept samples.
   pair_range_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lps_pkg::ST_SORT_CMP) |-> (pair_hi_wide < count_ff));
`endif
endmodule
`default_nettype wire

@@ verif/latency_percentile_stats_checker.sv @@
// Watches the channels of the statistics unit, predicts each result word and compares it.
`timescale 1ns / 1ps
`default_nettype none
module latency_percentile_stats_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire lps_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire lps_pkg::rsp_type rsp_data,
   input  wire logic             csr_write,
   input  wire logic [0:0]       csr_index,
   input  wire logic [31:0]      csr_wdata,
   output int                    errors,
   output int                    results_seen,
   output int                    pending
);
   // Predicted state of the set being loaded.
   logic [31:0] set_samples[$];
   logic [45:0] sum_acc;
   logic [14:0] low_count;
   logic [14:0] high_count;
   logic        dropped_seen;
   logic [31:0] low_thr;
   logic [31:0] high_thr;
   lps_pkg::rsp_type stats_expected[$];
   int          fail_count = 0;
   int          seen_count = 0;

   // Works out the result of a finished set.
   function automatic lps_pkg::rsp_type form_result();
      lps_pkg::rsp_type r;
      logic [31:0] sorted[$];
      int          n;
      sorted = set_samples;
      sorted.sort();
      n = sorted.size();
      r.min_latency      = sorted[0];
      r.max_latency      = sorted[n - 1];
      r.mean_latency     = 32'(sum_acc / 46'(n));
      r.median_latency   = sorted[(n * 50) / 100];
      r.p99_latency      = sorted[(n * 99) / 100];
      r.p999_latency     = sorted[(n * 999) / 1000];
      r.count_above_low  = low_count;
      r.count_above_high = high_count;
      r.sample_count     = 15'(n);
      r.samples_dropped  = dropped_seen;
      return r;
   endfunction

   function automatic int check_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (expv !== actv) begin
         $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, expv, actv);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         set_samples.delete();
         sum_acc = '0;
         low_count = '0;
         high_count = '0;
         dropped_seen = 1'b0;
         low_thr = lps_pkg::LOW_THRESHOLD_RESET;
         high_thr = lps_pkg::HIGH_THRESHOLD_RESET;
      end else begin
         if (csr_write) begin
            if (csr_index == lps_pkg::CSR_LOW_THRESHOLD) begin
               low_thr = csr_wdata;
            end else begin
               high_thr = csr_wdata;
            end
         end
         // An accepted word is loaded; the word marked last closes the set.
         if (req_valid && req_ready) begin
            if (set_samples.size() < lps_pkg::MAX_SAMPLES) begin
               set_samples.insert(set_samples.size(), req_data.latency_ns);
               sum_acc = sum_acc + 46'(req_data.latency_ns);
               if (req_data.latency_ns > low_thr) low_count = low_count + 1'b1;
               if (req_data.latency_ns > high_thr) high_count = high_count + 1'b1;
            end else begin
               dropped_seen = 1'b1;
            end
            if (req_data.last_sample) begin
               stats_expected.insert(stats_expected.size(), form_result());
               set_samples.delete();
               sum_acc = '0;
               low_count = '0;
               high_count = '0;
               dropped_seen = 1'b0;
            end
         end
         // Each result word is compared with the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            seen_count++;
            if (stats_expected.size() == 0) begin
               $display("%0t: unexpected result word, min %0d", $time, rsp_data.min_latency);
               fail_count++;
            end else begin
               lps_pkg::rsp_type e;
               e = stats_expected.pop_front();
               fail_count += check_field("min_latency", e.min_latency, rsp_data.min_latency);
               fail_count += check_field("max_latency", e.max_latency, rsp_data.max_latency);
               fail_count += check_field("mean_latency", e.mean_latency,
                                         rsp_data.mean_latency);
               fail_count += check_field("median_latency", e.median_latency,
                                         rsp_data.median_latency);
               fail_count += check_field("p99_latency", e.p99_latency, rsp_data.p99_latency);
               fail_count += check_field("p999_latency", e.p999_latency,
                                         rsp_data.p999_latency);
               fail_count += check_field("count_above_low", 32'(e.count_above_low),
                                         32'(rsp_data.count_above_low));
               fail_count += check_field("count_above_high", 32'(e.count_above_high),
                                         32'(rsp_data.count_above_high));
               fail_count += check_field("sample_count", 32'(e.sample_count),
                                         32'(rsp_data.sample_count));
               fail_count += check_field("samples_dropped", 32'(e.samples_dropped),
                                         32'(rsp_data.samples_dropped));
            end
         end
      end
      errors <= fail_count;
      results_seen <= seen_count;
      pending <= stats_expected.size();
   end
endmodule
`default_nettype wire

@@ verif/latency_percentile_stats_unit_tb.sv @@
// Top of the testbench: clock, reset, stimulus, and the final verdict.
`timescale 1ns / 1ps
`default_nettype none
module latency_percentile_stats_unit_tb;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int ITEM_TARGET = 1100;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   lps_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   lps_pkg::rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [0:0] csr_index = lps_pkg::CSR_LOW_THRESHOLD;
   logic [31:0] csr_wdata = '0;

   int errors;
   int results_seen;
   int pending;
   int cycles = 0;
   int words_sent = 0;
   int sets_sent = 0;
   int largest_set = 0;
   bit stall_free = 1'b0;

   always #5 clock = ~clock;

   latency_percentile_stats_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   latency_percentile_stats_checker stats_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .results_seen(results_seen), .pending(pending)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side: random stalls, with stall-free stretches.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
      if (stall_free) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= (pick_gap() == 0);
      end
      if ($urandom_range(199) == 0) stall_free <= ~stall_free;
   end

   // Sends one word and holds it until it is taken.
   task automatic send_word(input logic [31:0] lat, input logic last);
      int gap;
      req_valid <= 1'b1;
      req_data.latency_ns <= lat;
      req_data.last_sample <= last;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (last) sets_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every result has come back and the unit has settled.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_seen != sets_sent || pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [31:0] pick_sample(input logic [31:0] lo, input logic [31:0] hi);
      int r;
      r = $urandom_range(99);
      if (r < 30) return $urandom();
      if (r < 50) return lo + $urandom_range(0, 2) - 1;
      if (r < 65) return hi + $urandom_range(0, 2) - 1;
      if (r < 75) return $urandom_range(0, 3);
      if (r < 80) return 32'hFFFF_FFFF - $urandom_range(0, 3);
      return $urandom_range(0, 200000);
   endfunction

   task automatic send_set(input int n, input logic [31:0] lo, input logic [31:0] hi);
      logic [31:0] prev;
      prev = pick_sample(lo, hi);
      if (n > largest_set) largest_set = n;
      for (int i = 0; i < n; i++) begin
         // Repeat the previous value now and then to make ties.
         if ($urandom_range(5) != 0) prev = pick_sample(lo, hi);
         send_word(prev, i == n - 1);
      end
   endtask

   initial begin
      logic [31:0] lo;
      logic [31:0] hi;
      int          n;
      int          big_left;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sets at the reset thresholds: single words, extremes, edges.
      send_word(32'd0, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(lps_pkg::LOW_THRESHOLD_RESET, 1'b0);
      send_word(lps_pkg::LOW_THRESHOLD_RESET + 1, 1'b0);
      send_word(lps_pkg::HIGH_THRESHOLD_RESET, 1'b0);
      send_word(lps_pkg::HIGH_THRESHOLD_RESET + 1, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // Threshold extremes: low at zero and high at the maximum, then the other way round.
      write_reg(lps_pkg::CSR_LOW_THRESHOLD, 32'd0);
      write_reg(lps_pkg::CSR_HIGH_THRESHOLD, 32'hFFFF_FFFF);
      send_word(32'd0, 1'b0);
      send_word(32'd1, 1'b0);
      send_word(32'hFFFF_FFFE, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h5555_5555, 1'b0);
      send_word(32'hAAAA_AAAA, 1'b1);
      wait_idle();
      write_reg(lps_pkg::CSR_LOW_THRESHOLD, 32'hFFFF_FFFF);
      write_reg(lps_pkg::CSR_HIGH_THRESHOLD, 32'd0);
      send_word(32'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'd7, 1'b1);
      wait_idle();

      // Random sets, each phase under new thresholds; a few large sets
      // separate the p99 and p999 picks.
      big_left = 3;
      while (words_sent < ITEM_TARGET) begin
         case ($urandom_range(3))
            0: begin lo = $urandom(); hi = $urandom(); end
            1: begin lo = $urandom_range(0, 50000); hi = $urandom_range(50000, 150000); end
            2: begin lo = 32'd0; hi = 32'hFFFF_FFFF; end
            default: begin
               lo = lps_pkg::LOW_THRESHOLD_RESET;
               hi = lps_pkg::HIGH_THRESHOLD_RESET;
            end
         endcase
         write_reg(lps_pkg::CSR_LOW_THRESHOLD, lo);
         write_reg(lps_pkg::CSR_HIGH_THRESHOLD, hi);
         for (int s = 0; s < 8 && words_sent < ITEM_TARGET; s++) begin
            if (big_left > 0 && $urandom_range(15) == 0) begin
               n = 200;
               big_left--;
            end else if ($urandom_range(5) == 0) begin
               n = $urandom_range(17, 60);
            end else begin
               n = $urandom_range(1, 16);
            end
            send_set(n, lo, hi);
         end
         wait_idle();
      end

      wait_idle();
      repeat (50) @(posedge clock);
      $display("Sent %0d samples in %0d sets (largest %0d), %0d results checked.",
               words_sent, sets_sent, largest_set, results_seen);
      $display("Thresholds went through reset values, both extremes and random settings.");
      if (errors == 0 && pending == 0 && results_seen == sets_sent) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
design/lps_pkg.sv
design/lps_divider.sv
design/latency_percentile_stats_unit.sv
verif/latency_percentile_stats_checker.sv
verif/latency_percentile_stats_unit_tb.sv
